// ===== sv/fps_pkg.sv =====
// fps_pkg: shared constants, item structs and codes for the furthest point sampler
// depends on nothing; imported by every module of the block

package fps_pkg;

	localparam int MAX_POINTS   = 1024;
	localparam int COORD_BITS   = 16;
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int SQ_BITS      = 2 * COORD_BITS;
	localparam int DIST_BITS    = 2 * COORD_BITS + 2;
	localparam int IDX_BITS     = $clog2(MAX_POINTS);
	localparam int CNT_BITS     = $clog2(MAX_POINTS + 1);
	localparam int OUT_IDX_BITS = 10;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_SAMPLE = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_SWEEP,
		SEQ_DRAIN,
		SEQ_FETCH,
		SEQ_EMIT
	} seq_state_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		action_t action;
		coord_t  x_coord;
		coord_t  y_coord;
		coord_t  z_coord;
	} in_item_t;

	typedef struct packed {
		logic [OUT_IDX_BITS-1:0] sample_index;
		coord_t                  out_x;
		coord_t                  out_y;
		coord_t                  out_z;
		status_t                 status;
	} out_item_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct packed {
		logic                 valid;
		logic [IDX_BITS-1:0]  idx;
		logic [DIST_BITS-1:0] min_dist;
	} dist_res_t;

endpackage

// ===== sv/fps_dist_unit.sv =====
// fps_dist_unit: three-stage squared distance and running minimum, one point per cycle
// depends on fps_pkg

module fps_dist_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pt_valid,
	input  fps_pkg::point_t                 pt,
	input  logic [fps_pkg::IDX_BITS-1:0]    pt_idx,
	input  logic [fps_pkg::DIST_BITS-1:0]   pt_min,
	input  fps_pkg::point_t                 chosen,
	output fps_pkg::dist_res_t              res
);
	import fps_pkg::*;

	logic signed [DIFF_BITS-1:0]   dx, dy, dz;
	logic signed [DIFF_BITS-1:0]   dx_s2, dy_s2, dz_s2;
	logic                          v_s2, v_s3, v_s4;
	logic [IDX_BITS-1:0]           idx_s2, idx_s3, idx_s4;
	logic [DIST_BITS-1:0]          min_s2, min_s3, min_s4;
	logic signed [2*DIFF_BITS-1:0] px, py, pz;
	logic [SQ_BITS-1:0]            sqx_s3, sqy_s3, sqz_s3;
	logic [DIST_BITS-1:0]          sum, new_min;

	assign dx = DIFF_BITS'(pt.x) - DIFF_BITS'(chosen.x);
	assign dy = DIFF_BITS'(pt.y) - DIFF_BITS'(chosen.y);
	assign dz = DIFF_BITS'(pt.z) - DIFF_BITS'(chosen.z);

	assign px = dx_s2 * dx_s2;
	assign py = dy_s2 * dy_s2;
	assign pz = dz_s2 * dz_s2;

	assign sum = DIST_BITS'(sqx_s3) + DIST_BITS'(sqy_s3) + DIST_BITS'(sqz_s3);
	assign new_min = (sum < min_s3) ? sum : min_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= pt_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2  <= dx;
		dy_s2  <= dy;
		dz_s2  <= dz;
		idx_s2 <= pt_idx;
		min_s2 <= pt_min;
		sqx_s3 <= px[SQ_BITS-1:0];
		sqy_s3 <= py[SQ_BITS-1:0];
		sqz_s3 <= pz[SQ_BITS-1:0];
		idx_s3 <= idx_s2;
		min_s3 <= min_s2;
		idx_s4 <= idx_s3;
		min_s4 <= new_min;
	end

	assign res = '{valid: v_s4, idx: idx_s4, min_dist: min_s4};

endmodule

// ===== sv/furthest_point_sampler_top.sv =====
// furthest_point_sampler_top: point store, minimum distance store and sweep sequencer
// depends on fps_pkg and fps_dist_unit
//
//  channel  | direction | handshake              | payload
//  req      | in        | req_valid / req_stall  | fps_pkg::in_item_t
//  rsp      | out       | rsp_valid / rsp_stall  | fps_pkg::out_item_t
//
// a load, clear or ignored action completes when it is accepted; an error result is registered at once
// the first sample request after a clear skips the sweep and returns point 0
// later requests sweep the cloud, one store read per point through the single read port
// of the point store, then drain the dist unit pipeline
// reset empties the cloud; store contents are not cleared
// a finished result waits in the output register; req is stalled while a sample runs

module furthest_point_sampler_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  fps_pkg::in_item_t    req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output fps_pkg::out_item_t   rsp
);
	import fps_pkg::*;

	point_t               pt_mem  [MAX_POINTS];
	logic [DIST_BITS-1:0] min_mem [MAX_POINTS];

	seq_state_t           state_q, state_d;
	logic [CNT_BITS-1:0]  count_q;
	logic [IDX_BITS-1:0]  idx_q;
	logic [IDX_BITS-1:0]  best_idx_q;
	logic [DIST_BITS-1:0] best_q;
	logic                 started_q;
	point_t               chosen_q;
	logic                 rsp_valid_q;
	out_item_t            rsp_q;

	point_t               pt_s1;
	logic [DIST_BITS-1:0] min_s1;
	logic [IDX_BITS-1:0]  idx_s1;
	logic                 v_s1;
	dist_res_t            res;

	logic                 accept, rsp_free, full, last_issue, last_done;
	logic                 rd_en, emit_now, err_now;
	logic [IDX_BITS-1:0]  rd_addr;
	logic                 is_load, is_sample, is_clear;

	assign rsp_free   = !rsp_valid_q || !rsp_stall;
	assign accept     = req_valid && !req_stall;
	assign is_load    = accept && (req.action == ACT_LOAD);
	assign is_sample  = accept && (req.action == ACT_SAMPLE);
	assign is_clear   = accept && (req.action == ACT_CLEAR);
	assign full       = (count_q == CNT_BITS'(MAX_POINTS));
	assign last_issue = ((CNT_BITS'(idx_q) + CNT_BITS'(1)) == count_q);
	assign last_done  = res.valid && ((CNT_BITS'(res.idx) + CNT_BITS'(1)) == count_q);
	assign err_now    = (is_load && full) || (is_sample && (count_q == '0));

	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (is_sample && (count_q != '0))
					state_d = started_q ? SEQ_SWEEP : SEQ_FETCH;
			end
			SEQ_SWEEP: begin
				if (last_issue)
					state_d = SEQ_DRAIN;
			end
			SEQ_DRAIN: begin
				if (last_done)
					state_d = SEQ_FETCH;
			end
			SEQ_FETCH: state_d = SEQ_EMIT;
			SEQ_EMIT: begin
				if (rsp_free)
					state_d = SEQ_IDLE;
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		req_stall = !rsp_free;
		rd_en     = 1'b0;
		rd_addr   = best_idx_q;
		emit_now  = 1'b0;
		case (state_q)
			SEQ_IDLE: ;
			SEQ_SWEEP: begin
				req_stall = 1'b1;
				rd_en     = 1'b1;
				rd_addr   = idx_q;
			end
			SEQ_DRAIN: req_stall = 1'b1;
			SEQ_FETCH: begin
				req_stall = 1'b1;
				rd_en     = 1'b1;
			end
			SEQ_EMIT: begin
				req_stall = 1'b1;
				emit_now  = rsp_free;
			end
			default: req_stall = 1'b1;
		endcase
	end

	// point store and minimum distance store
	always_ff @(posedge clk) begin
		if (is_load && !full)
			pt_mem[count_q[IDX_BITS-1:0]] <= '{x: req.x_coord, y: req.y_coord, z: req.z_coord};
		if (is_load && !full)
			min_mem[count_q[IDX_BITS-1:0]] <= '1;
		else if (res.valid)
			min_mem[res.idx] <= res.min_dist;
		if (rd_en) begin
			pt_s1  <= pt_mem[rd_addr];
			min_s1 <= min_mem[rd_addr];
		end
		idx_s1 <= idx_q;
	end

	fps_dist_unit u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (v_s1),
		.pt       (pt_s1),
		.pt_idx   (idx_s1),
		.pt_min   (min_s1),
		.chosen   (chosen_q),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			best_idx_q  <= '0;
			started_q   <= 1'b0;
			chosen_q    <= '0;
			rsp_valid_q <= 1'b0;
			v_s1        <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == SEQ_SWEEP);

			if (state_q == SEQ_SWEEP)
				idx_q <= idx_q + IDX_BITS'(1);
			else
				idx_q <= '0;

			if (is_sample)
				best_idx_q <= '0;
			else if (res.valid && ((res.idx == '0) || (res.min_dist > best_q)))
				best_idx_q <= res.idx;

			if (is_clear)
				count_q <= '0;
			else if (is_load && !full)
				count_q <= count_q + CNT_BITS'(1);

			if (is_clear) begin
				started_q <= 1'b0;
				chosen_q  <= '0;
			end else if (emit_now) begin
				started_q <= 1'b1;
				chosen_q  <= pt_s1;
			end

			if (emit_now || err_now)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && ((res.idx == '0) || (res.min_dist > best_q)))
			best_q <= res.min_dist;
		if (emit_now) begin
			rsp_q.sample_index <= OUT_IDX_BITS'(best_idx_q);
			rsp_q.out_x        <= pt_s1.x;
			rsp_q.out_y        <= pt_s1.y;
			rsp_q.out_z        <= pt_s1.z;
			rsp_q.status       <= STAT_OK;
		end else if (err_now) begin
			rsp_q.sample_index <= '0;
			rsp_q.out_x        <= '0;
			rsp_q.out_y        <= '0;
			rsp_q.out_z        <= '0;
			rsp_q.status       <= (req.action == ACT_LOAD) ? STAT_FULL : STAT_EMPTY;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== sv/fps_checker.sv =====
// fps_checker: port-level checks on the furthest point sampler, bound to the top level
// depends on fps_pkg and furthest_point_sampler_top

module fps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input fps_pkg::in_item_t  req,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input fps_pkg::out_item_t rsp
);
	import fps_pkg::*;

	// held result item stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp item changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == STAT_OK) || (rsp.status == STAT_EMPTY) ||
			(rsp.status == STAT_FULL))
		else $error("rsp status code out of range");

	// error items carry no point
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STAT_OK) |->
			(rsp.sample_index == '0) && (rsp.out_x == '0) && (rsp.out_y == '0) &&
			(rsp.out_z == '0))
		else $error("error item with nonzero payload");

	// an accepted sample request either starts work or answers at once
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.action == ACT_SAMPLE) |=> req_stall || rsp_valid)
		else $error("sample request accepted with no work and no result");

endmodule

bind furthest_point_sampler_top fps_checker u_fps_checker (.*);

// ===== tb/tb_furthest_point_sampler_top.sv =====
`timescale 1ns / 100ps
// tb_furthest_point_sampler_top: self-checking bench for the furthest point sampler
// drives load, sample and clear commands and checks every answer against its own cloud model
// depends on fps_pkg and furthest_point_sampler_top

module tb_furthest_point_sampler_top;
	import fps_pkg::*;

	localparam int     HALF_PERIOD = 5;
	localparam int     RESET_CYCLES = 5;
	localparam int     LONG_HOLD = 300;
	localparam int     SETTLE_CYCLES = 64;
	localparam int     QUIET_LIMIT = 10000;
	localparam coord_t C_MIN = 16'sh8000;
	localparam coord_t C_MAX = 16'sh7fff;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	in_item_t  req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	out_item_t rsp;

	in_item_t  pending_cmds[$];
	out_item_t due_samples[$];
	out_item_t want_ans;
	int        sent_cnt = 0;
	int        live_cnt = 0;
	int        taken_cnt = 0;
	int        fail_cnt = 0;
	int        send_gap_pct = 0;
	int        recv_gap_pct = 0;
	int        hold_left = 0;
	int        quiet_cycles = 0;
	bit        hold_armed = 1'b0;
	bit        hold_taken = 1'b0;
	logic      req_taken = 1'b0;

	// cloud model
	point_t               cloud_pts[MAX_POINTS];
	logic [DIST_BITS-1:0] nearest_dist[MAX_POINTS];
	int                   cloud_size = 0;
	bit                   sweep_begun = 1'b0;
	point_t               last_pick = '0;

	wire req_fire = req_valid && !req_stall;
	wire rsp_fire = rsp_valid && !rsp_stall;

	furthest_point_sampler_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #HALF_PERIOD clk = ~clk;

	task automatic predict_fps_answer(input in_item_t cmd);
		out_item_t            ans;
		logic [DIST_BITS-1:0] d;
		logic [DIST_BITS-1:0] best;
		int                   best_idx;
		int                   i;
		longint               dx, dy, dz;
		ans = '0;
		case (cmd.action)
		ACT_LOAD: begin
			if (cloud_size >= MAX_POINTS) begin
				ans.status = STAT_FULL;
				due_samples.push_back(ans);
			end else begin
				cloud_pts[cloud_size] = '{cmd.x_coord, cmd.y_coord, cmd.z_coord};
				nearest_dist[cloud_size] = '1;
				cloud_size++;
			end
		end
		ACT_CLEAR: begin
			cloud_size = 0;
			sweep_begun = 1'b0;
			last_pick = '0;
		end
		ACT_SAMPLE: begin
			if (cloud_size == 0) begin
				ans.status = STAT_EMPTY;
				due_samples.push_back(ans);
			end else begin
				best_idx = 0;
				best = '0;
				if (sweep_begun) begin
					for (i = 0; i < cloud_size; i++) begin
						dx = longint'(cloud_pts[i].x) - longint'(last_pick.x);
						dy = longint'(cloud_pts[i].y) - longint'(last_pick.y);
						dz = longint'(cloud_pts[i].z) - longint'(last_pick.z);
						d = DIST_BITS'(dx * dx + dy * dy + dz * dz);
						if (d < nearest_dist[i])
							nearest_dist[i] = d;
						if (i == 0 || nearest_dist[i] > best) begin
							best = nearest_dist[i];
							best_idx = i;
						end
					end
				end
				sweep_begun = 1'b1;
				last_pick = cloud_pts[best_idx];
				ans.sample_index = OUT_IDX_BITS'(best_idx);
				ans.out_x = last_pick.x;
				ans.out_y = last_pick.y;
				ans.out_z = last_pick.z;
				ans.status = STAT_OK;
				due_samples.push_back(ans);
			end
		end
		default: ;
		endcase
	endtask

	task automatic flag_field(input string name, input longint want, input longint got);
		$error("%s mismatch: expected %0d, got %0d", name, want, got);
		fail_cnt++;
	endtask

	function automatic coord_t pick_coord();
		case ($urandom_range(9))
		0: return C_MIN;
		1: return C_MAX;
		2, 3, 4: return coord_t'(int'($urandom_range(8)) - 4);
		default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic queue_cmd(input action_t act, input coord_t x, input coord_t y,
		input coord_t z);
		in_item_t cmd;
		cmd.action = act;
		cmd.x_coord = x;
		cmd.y_coord = y;
		cmd.z_coord = z;
		pending_cmds.push_back(cmd);
		sent_cnt++;
		if (act != ACT_NONE)
			live_cnt++;
	endtask

	task automatic queue_point();
		queue_cmd(ACT_LOAD, pick_coord(), pick_coord(), pick_coord());
	endtask

	task automatic queue_plain(input action_t act);
		queue_cmd(act, pick_coord(), pick_coord(), pick_coord());
	endtask

	// mostly clear first, load a small cloud, then take up to its size plus two samples
	task automatic queue_cloud_run();
		int n_pts;
		int n_samples;
		n_pts = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
		if ($urandom_range(9) != 0)
			queue_plain(ACT_CLEAR);
		repeat (n_pts) queue_point();
		n_samples = $urandom_range(1, n_pts + 2);
		repeat (n_samples) begin
			if ($urandom_range(9) == 0)
				queue_point();
			queue_plain(ACT_SAMPLE);
		end
	endtask

	task automatic queue_random_mix(input int n_cmds);
		int target;
		target = live_cnt + n_cmds;
		while (live_cnt < target) begin
			case ($urandom_range(9))
			0: queue_plain(action_t'($urandom_range(3)));
			1: begin
				queue_plain(ACT_CLEAR);
				queue_plain(ACT_SAMPLE);
			end
			default: queue_cloud_run();
			endcase
		end
	endtask

	task automatic wait_for_drain();
		while (taken_cnt != sent_cnt || due_samples.size() != 0)
			@(posedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (!req_valid || req_taken) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				req <= pending_cmds.pop_front();
				req_valid <= 1'b1;
			end else
				req_valid <= 1'b0;
		end
	end

	// answer receiver, with one long hold-off
	always @(negedge clk) begin
		if (hold_armed && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= LONG_HOLD;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else
			rsp_stall <= ($urandom_range(99) < recv_gap_pct);
	end

	// monitor and checker
	always @(posedge clk) begin
		req_taken <= req_fire;
		if (arst_n && rsp_fire) begin
			if (due_samples.size() == 0) begin
				$error("answer arrived with none expected");
				fail_cnt++;
			end else begin
				want_ans = due_samples.pop_front();
				if (rsp.sample_index !== want_ans.sample_index)
					flag_field("sample_index", want_ans.sample_index, rsp.sample_index);
				if (rsp.out_x !== want_ans.out_x)
					flag_field("out_x", want_ans.out_x, rsp.out_x);
				if (rsp.out_y !== want_ans.out_y)
					flag_field("out_y", want_ans.out_y, rsp.out_y);
				if (rsp.out_z !== want_ans.out_z)
					flag_field("out_z", want_ans.out_z, rsp.out_z);
				if (rsp.status !== want_ans.status)
					flag_field("status", want_ans.status, rsp.status);
			end
		end
		if (arst_n && req_fire) begin
			taken_cnt <= taken_cnt + 1;
			predict_fps_answer(req);
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if (!arst_n || req_fire || rsp_fire)
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		send_gap_pct = 26;
		recv_gap_pct = 83;

		queue_cmd(ACT_SAMPLE, C_MAX, C_MIN, C_MAX);
		queue_cmd(ACT_LOAD, C_MIN, C_MIN, C_MIN);
		queue_cmd(ACT_LOAD, C_MAX, C_MAX, C_MAX);
		queue_cmd(ACT_LOAD, '0, '0, '0);
		queue_cmd(ACT_LOAD, -16'sd1, C_MAX, C_MIN);
		// more samples than points: minima reach zero
		repeat (6) queue_cmd(ACT_SAMPLE, '0, '0, '0);
		// load while sampling joins later sweeps
		queue_cmd(ACT_LOAD, 16'sd1, 16'sd2, 16'sd3);
		repeat (2) queue_cmd(ACT_SAMPLE, C_MIN, C_MIN, C_MIN);
		queue_cmd(ACT_NONE, C_MIN, C_MAX, -16'sd1);
		queue_cmd(ACT_CLEAR, C_MAX, C_MAX, C_MAX);
		queue_cmd(ACT_SAMPLE, '0, '0, '0);
		// equal distances and a duplicate point
		queue_cmd(ACT_LOAD, '0, '0, '0);
		queue_cmd(ACT_LOAD, 16'sd2, '0, '0);
		queue_cmd(ACT_LOAD, -16'sd2, '0, '0);
		queue_cmd(ACT_LOAD, 16'sd2, '0, '0);
		repeat (3) queue_cmd(ACT_SAMPLE, '0, '0, '0);
		wait_for_drain();

		queue_random_mix(182);
		wait_for_drain();

		send_gap_pct = 83;
		recv_gap_pct = 26;
		queue_random_mix(182);
		wait_for_drain();

		send_gap_pct = 0;
		recv_gap_pct = 0;
		hold_armed = 1'b1;
		queue_random_mix(183);
		wait_for_drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
